/* hdl/dos_short_path_validator_defines.svh */
// ----------------------------------------------------------------------------
// dos_short_path_validator_defines.svh
// Assertion macros shared by the path validator RTL.
// ----------------------------------------------------------------------------
`ifndef DOS_SHORT_PATH_VALIDATOR_DEFINES_SVH
`define DOS_SHORT_PATH_VALIDATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion, ignored while reset is high.
`define DSPV_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dspv: %m check failed");
// Clocked assertion, also checked during reset.
`define DSPV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dspv: %m check failed");
`else
`define DSPV_ASSERT(label, clk, rst, prop)
`define DSPV_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* hdl/dspv_pkg.sv */
// ----------------------------------------------------------------------------
// dspv_pkg
// Character constants and the name character class for the path validator.
// ----------------------------------------------------------------------------
package dspv_pkg;

  localparam int unsigned CHAR_W = 16;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [3:0]        base_cnt_t;
  typedef logic [2:0]        ext_cnt_t;

  localparam char_t     CHAR_NUL    = 16'h0000;
  localparam char_t     CHAR_DOT    = 16'h002E;
  localparam char_t     CHAR_BSLASH = 16'h005C;
  localparam base_cnt_t BASE_MAX    = 4'd8;
  localparam ext_cnt_t  EXT_MAX     = 3'd3;

  // Letters, digits and the allowed punctuation; ASCII only.
  function automatic logic name_char(input char_t c);
    logic ok;
    case (c) inside
      [16'h0041:16'h005A],
      [16'h0061:16'h007A],
      [16'h0030:16'h0039],
      16'h0024, 16'h0025, 16'h0027, 16'h002D, 16'h005F,
      16'h0040, 16'h007E, 16'h0021, 16'h0023, 16'h0028,
      16'h0029, 16'h007B, 16'h007D, 16'h005E: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

/* hdl/dos_short_path_validator.sv */
// Pipeline: a terminator passes the input register and then the result register,
//   whose verdict is shown on path_valid/result_valid.
// Throughput: one character per cycle; the only stall is a terminator that
//   finds the result register still full.
// Reset: synchronous, active-high rst empties both stages and clears all
//   component, failure and length state.
// ----------------------------------------------------------------------------
// dos_short_path_validator
// Checks a relative DOS path, one UTF-16 character per transfer, against
// 8.3 component rules and returns one verdict per zero terminator.
// ----------------------------------------------------------------------------
`include "dos_short_path_validator_defines.svh"

module dos_short_path_validator #(
  parameter int unsigned MAX_RELATIVE = 128  // path length limit, 2..255
) (
  input  logic        clk,
  input  logic        rst,
  // character channel
  input  logic [15:0] char_code,
  input  logic        char_valid,
  output logic        char_ready,
  // verdict channel
  output logic        path_valid,
  output logic        result_valid,
  input  logic        result_ready
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_RELATIVE);

  // Input register: one character waiting to be scored.
  logic               s1_valid;
  dspv_pkg::char_t    s1_char;

  // Path state.
  dspv_pkg::base_cnt_t base_count, base_count_next;
  dspv_pkg::ext_cnt_t  ext_count,  ext_count_next;
  logic                dot_seen,   dot_seen_next;
  logic                failed,     failed_next;
  logic [7:0]          char_count, char_count_next;

  logic s1_term;
  logic s1_fire;
  logic complete;
  logic verdict;

  // A terminator may only leave the input register when the result
  // register is empty or being emptied in this cycle; other characters
  // never wait.
  assign s1_term    = (s1_char == dspv_pkg::CHAR_NUL);
  assign s1_fire    = s1_valid && (!s1_term || !result_valid || result_ready);
  assign char_ready = !s1_valid || s1_fire;

  // Current component is a closed 8.3 name.
  assign complete = (base_count != '0) && (!dot_seen || (ext_count != '0));

  assign verdict = !failed && (char_count < MAX_LEN) &&
                   ((char_count == '0) || complete);

  always_comb begin
    base_count_next = base_count;
    ext_count_next  = ext_count;
    dot_seen_next   = dot_seen;
    failed_next     = failed;
    char_count_next = char_count;

    if (s1_fire) begin
      if (s1_term) begin
        // Verdict taken; start a fresh path.
        base_count_next = '0;
        ext_count_next  = '0;
        dot_seen_next   = 1'b0;
        failed_next     = 1'b0;
        char_count_next = '0;
      end else begin
        if (char_count < MAX_LEN) begin
          char_count_next = char_count + 8'd1;
        end
        // After a failure only the length keeps counting.
        if (!failed) begin
          if (s1_char == dspv_pkg::CHAR_BSLASH) begin
            if (!complete) begin
              failed_next = 1'b1;
            end
            base_count_next = '0;
            ext_count_next  = '0;
            dot_seen_next   = 1'b0;
          end else if (s1_char == dspv_pkg::CHAR_DOT) begin
            if (dot_seen || (base_count == '0)) begin
              failed_next = 1'b1;
            end else begin
              dot_seen_next = 1'b1;
            end
          end else if (!dspv_pkg::name_char(s1_char)) begin
            failed_next = 1'b1;
          end else if (dot_seen) begin
            if (ext_count >= dspv_pkg::EXT_MAX) begin
              failed_next = 1'b1;
            end else begin
              ext_count_next = ext_count + 3'd1;
            end
          end else begin
            if (base_count >= dspv_pkg::BASE_MAX) begin
              failed_next = 1'b1;
            end else begin
              base_count_next = base_count + 4'd1;
            end
          end
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      s1_char <= char_code;
    end
  end

  // Path state.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_count <= '0;
      ext_count  <= '0;
      dot_seen   <= 1'b0;
      failed     <= 1'b0;
      char_count <= '0;
    end else begin
      base_count <= base_count_next;
      ext_count  <= ext_count_next;
      dot_seen   <= dot_seen_next;
      failed     <= failed_next;
      char_count <= char_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_term) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_term) begin
      path_valid <= verdict;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A failure holds until a terminator is scored.
  `DSPV_ASSERT(a_failed_sticks, clk, rst,
               failed && !(s1_fire && s1_term) |=> failed)
  // Component counters never pass the 8.3 limits; length never passes the cap.
  `DSPV_ASSERT(a_counts_bounded, clk, rst,
               (base_count <= dspv_pkg::BASE_MAX) && (ext_count <= dspv_pkg::EXT_MAX) &&
               (char_count <= MAX_LEN))
  // Scoring a terminator raises a result and leaves a clean path state.
  `DSPV_ASSERT(a_term_clears, clk, rst,
               s1_fire && s1_term |=> result_valid && (char_count == '0) && !failed &&
               !dot_seen)

endmodule
